// ===== design/gkc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package gkc_pkg;

	localparam int MAX_NODES   = 32;
	localparam int DIST_W      = 16;
	localparam int ID_W        = $clog2(MAX_NODES);
	localparam int COUNT_W     = $clog2(MAX_NODES + 1);
	localparam int STORE_DEPTH = MAX_NODES * MAX_NODES;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int CFG_IDX_W   = 1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_NODES_IN_USE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_COUNT = 1'b1;

	localparam logic [COUNT_W-1:0] NODES_RESET  = COUNT_W'(MAX_NODES);
	localparam logic [COUNT_W-1:0] CENTER_RESET = COUNT_W'(1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEED,
		ST_SEED_WAIT,
		ST_SEARCH,
		ST_UPDATE,
		ST_UPDATE_WAIT,
		ST_EMIT_CTR,
		ST_EMIT_LBL
	} gkc_state_t;

	typedef struct packed {
		logic run_init;
		logic seed_issue;
		logic search_step;
		logic update_issue;
		logic round_next;
		logic emit_center;
		logic emit_label;
		logic cnt_clear;
	} gkc_cmd_t;

	typedef struct packed {
		logic cnt_n_last;
		logic cnt_k_last;
		logic round_last;
		logic single_center;
	} gkc_status_t;

endpackage

`default_nettype wire

// ===== design/gkc_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gkc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== design/gkc_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gkc_ctrl
	import gkc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic        last_entry,
	input  wire gkc_status_t status,
	output gkc_cmd_t         cmd,
	output logic             busy
);

	gkc_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start && last_entry) begin
					cmd.run_init = 1'b1;
					state_d      = ST_SEED;
				end
			end
			ST_SEED: begin
				cmd.seed_issue = 1'b1;
				if (status.cnt_n_last) begin
					cmd.cnt_clear = 1'b1;
					state_d       = ST_SEED_WAIT;
				end
			end
			ST_SEED_WAIT: begin
				state_d = status.single_center ? ST_EMIT_CTR : ST_SEARCH;
			end
			ST_SEARCH: begin
				cmd.search_step = 1'b1;
				if (status.cnt_n_last) begin
					cmd.cnt_clear = 1'b1;
					state_d       = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				cmd.update_issue = 1'b1;
				if (status.cnt_n_last) begin
					cmd.cnt_clear = 1'b1;
					state_d       = ST_UPDATE_WAIT;
				end
			end
			ST_UPDATE_WAIT: begin
				if (status.round_last) begin
					state_d = ST_EMIT_CTR;
				end else begin
					cmd.round_next = 1'b1;
					state_d        = ST_SEARCH;
				end
			end
			ST_EMIT_CTR: begin
				cmd.emit_center = 1'b1;
				if (status.cnt_k_last) begin
					cmd.cnt_clear = 1'b1;
					state_d       = ST_EMIT_LBL;
				end
			end
			ST_EMIT_LBL: begin
				cmd.emit_label = 1'b1;
				if (status.cnt_n_last) begin
					cmd.cnt_clear = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== design/gkc_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gkc_dp
	import gkc_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 accept,
	input  wire logic [DIST_W-1:0]    distance,
	input  wire logic                 last_entry,
	input  wire logic                 cfg_write,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [COUNT_W-1:0]   cfg_data,
	input  wire gkc_cmd_t             cmd,
	output gkc_status_t               status,
	output logic                      result_valid,
	output logic                      result_kind,
	output logic [ID_W-1:0]           position,
	output logic [ID_W-1:0]           node_id,
	output logic                      last_result
);

	function automatic logic [COUNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] v);
		logic [COUNT_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = COUNT_W'(1);
		end else if (v > COUNT_W'(MAX_NODES)) begin
			r = COUNT_W'(MAX_NODES);
		end
		return r;
	endfunction

	logic [COUNT_W-1:0] nodes_q, centers_q;
	logic [ADDR_W-1:0]  load_cnt_q;
	logic [ID_W-1:0]    cnt_q, round_q, far_q;
	logic [ADDR_W-1:0]  row_q;
	logic [DIST_W-1:0]  best_q;
	logic               seed_s1, upd_s1;
	logic [ID_W-1:0]    idx_s1;

	logic [DIST_W-1:0]  min_q    [MAX_NODES];
	logic [ID_W-1:0]    label_q  [MAX_NODES];
	logic [ID_W-1:0]    center_q [MAX_NODES];

	logic [COUNT_W-1:0] n_m1, k_m1;
	logic [ADDR_W-1:0]  raddr;
	logic [DIST_W-1:0]  rdata;
	logic [ID_W-1:0]    min_idx;
	logic [DIST_W-1:0]  min_rd;
	logic               take;
	logic [DIST_W-1:0]  best_nx;
	logic [ID_W-1:0]    far_nx;

	assign n_m1 = nodes_q - COUNT_W'(1);
	assign k_m1 = centers_q - COUNT_W'(1);

	assign status.cnt_n_last    = (cnt_q == n_m1[ID_W-1:0]);
	assign status.cnt_k_last    = (cnt_q == k_m1[ID_W-1:0]);
	assign status.round_last    = (round_q == k_m1[ID_W-1:0]);
	assign status.single_center = (centers_q == COUNT_W'(1));

	// one read port on the minimum array: search walks it, stage 1 updates it
	assign min_idx = cmd.search_step ? cnt_q : idx_s1;
	assign min_rd  = min_q[min_idx];

	assign take    = (cnt_q == '0) || (min_rd > best_q);
	assign best_nx = take ? min_rd : best_q;
	assign far_nx  = take ? cnt_q : far_q;

	assign raddr = cmd.update_issue ? (row_q + ADDR_W'(far_q)) : ADDR_W'(cnt_q);

	gkc_ram #(
		.WIDTH(DIST_W),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (accept),
		.waddr(load_cnt_q),
		.wdata(distance),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nodes_q      <= NODES_RESET;
			centers_q    <= CENTER_RESET;
			load_cnt_q   <= '0;
			cnt_q        <= '0;
			round_q      <= '0;
			seed_s1      <= 1'b0;
			upd_s1       <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			if (cfg_write && cfg_index == REG_NODES_IN_USE) begin
				nodes_q <= clamp_count(cfg_data);
			end
			if (cfg_write && cfg_index == REG_CENTER_COUNT) begin
				centers_q <= clamp_count(cfg_data);
			end
			if (accept) begin
				load_cnt_q <= last_entry ? '0 : load_cnt_q + ADDR_W'(1);
			end
			if (cmd.cnt_clear || cmd.run_init) begin
				cnt_q <= '0;
			end else if (cmd.seed_issue || cmd.search_step || cmd.update_issue ||
					cmd.emit_center || cmd.emit_label) begin
				cnt_q <= cnt_q + ID_W'(1);
			end
			if (cmd.run_init) begin
				round_q <= ID_W'(1);
			end else if (cmd.round_next) begin
				round_q <= round_q + ID_W'(1);
			end
			seed_s1      <= cmd.seed_issue;
			upd_s1       <= cmd.update_issue;
			result_valid <= cmd.emit_center || cmd.emit_label;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q;
		if (cmd.run_init) begin
			center_q[0] <= '0;
		end
		if (cmd.search_step) begin
			best_q <= best_nx;
			far_q  <= far_nx;
			if (status.cnt_n_last) begin
				center_q[round_q] <= far_nx;
				row_q             <= '0;
			end
		end
		if (cmd.update_issue) begin
			row_q <= row_q + ADDR_W'(nodes_q);
		end
		if (seed_s1) begin
			min_q[idx_s1]   <= rdata;
			label_q[idx_s1] <= '0;
		end else if (upd_s1 && (rdata < min_rd)) begin
			min_q[idx_s1]   <= rdata;
			label_q[idx_s1] <= far_q;
		end
		if (cmd.emit_center) begin
			result_kind <= 1'b0;
			position    <= cnt_q;
			node_id     <= center_q[cnt_q];
			last_result <= 1'b0;
		end else if (cmd.emit_label) begin
			result_kind <= 1'b1;
			position    <= cnt_q;
			node_id     <= label_q[cnt_q];
			last_result <= status.cnt_n_last;
		end
	end

endmodule

`default_nettype wire

// ===== design/greedy_k_center_selector.sv =====
`timescale 1ns / 1ps
`default_nettype none

// greedy farthest-point k-center selector. load the n x n distance matrix
// row-major, one entry per start pulse while busy is low; entries go to a
// 1024-deep store at a running address that wraps and is reset by the entry
// flagged last_entry. that flagged entry starts a run and raises busy: no
// item is taken until the run ends. a run first seeds the minima from row 0
// (reads of row 0, then a drain state), then for each extra center scans the
// minimum distances, streams one matrix column from the store's single read
// port and drains, then emits the results. results come out one per cycle
// on result_valid with no back-pressure: the k center ids first (result_kind
// 0), then each node's nearest center (result_kind 1), last_result on the
// final one. busy drops in the cycle the last result is shown. write
// nodes_in_use and center_count only while busy is low; values outside 1..32
// are clamped

module greedy_k_center_selector
	import gkc_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// item side
	input  wire logic                 start,
	output logic                      busy,
	input  wire logic [DIST_W-1:0]    distance,
	input  wire logic                 last_entry,
	// configuration writes
	input  wire logic                 cfg_write,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [COUNT_W-1:0]   cfg_data,
	// result side
	output logic                      result_valid,
	output logic                      result_kind,
	output logic [ID_W-1:0]           position,
	output logic [ID_W-1:0]           node_id,
	output logic                      last_result
);

	gkc_cmd_t    cmd;
	gkc_status_t status;
	logic        accept;

	// an item is taken only between runs
	assign accept = start && !busy;

	gkc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.last_entry(last_entry),
		.status    (status),
		.cmd       (cmd),
		.busy      (busy)
	);

	// datapath holds the store, per-node minimum and label, center list
	gkc_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.distance    (distance),
		.last_entry  (last_entry),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.cmd         (cmd),
		.status      (status),
		.result_valid(result_valid),
		.result_kind (result_kind),
		.position    (position),
		.node_id     (node_id),
		.last_result (last_result)
	);

endmodule

`default_nettype wire
